// File: design/llca_pkg.sv
// Package for the life-like automaton cell engine: sizes, field widths,
// function and register codes, and the microcode ROM of the sequencer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package llca_pkg;

  // Grid storage
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int CELL_BITS  = 8;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS  = $clog2(DEPTH);

  // Transaction field widths
  localparam int FUNC_BITS  = 2;
  localparam int ROW_BITS   = 7;
  localparam int COL_BITS   = 7;
  localparam int VALUE_BITS = 8;
  localparam int COUNT_BITS = 4;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam int SIZE_BITS     = 8;
  localparam int RULE_BITS     = 4;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EVAL  = 2'd1,
    FUNC_SWAP  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_BIRTH_COUNT = 3'd2,
    REG_SURVIVE_MIN = 3'd3,
    REG_SURVIVE_MAX = 3'd4,
    REG_ALIVE_LEVEL = 3'd5,
    REG_DECAY_STEP  = 3'd6
  } reg_idx_t;

  // Neighbor offset select for row and column
  typedef enum logic [1:0] {
    OFS_CENTER = 2'b00,
    OFS_MINUS  = 2'b01,
    OFS_PLUS   = 2'b10
  } ofs_t;

  // Control word
  typedef struct packed {
    ofs_t rsel;       // row of current-bank access
    ofs_t csel;       // column of current-bank access
    logic rd_cur;     // read current bank
    logic wr_cur;     // write write_value into current bank
    logic take_self;  // capture read data as the cell itself
    logic count_nb;   // compare read data with alive level, count
    logic wr_next;    // apply rule, write next bank, emit new value
    logic take_read;  // emit read data
    logic swap;       // toggle bank select
    logic disp;       // jump by function and coordinate check
    logic last;       // emit result and end
  } uop_t;

  localparam int STEP_BITS = 5;
  localparam logic [STEP_BITS-1:0] STEP_DISPATCH = 5'd0;
  localparam logic [STEP_BITS-1:0] STEP_EVAL     = 5'd1;
  localparam logic [STEP_BITS-1:0] STEP_WRITE    = 5'd12;
  localparam logic [STEP_BITS-1:0] STEP_READ     = 5'd13;
  localparam logic [STEP_BITS-1:0] STEP_SWAP     = 5'd15;
  localparam logic [STEP_BITS-1:0] STEP_BAD      = 5'd16;

  // Microcode program
  function automatic uop_t uop_rom(input logic [STEP_BITS-1:0] step);
    uop_t u;
    u = '0;
    case (step)
      5'd0:  u.disp = 1'b1;
      // evaluate: self, then the eight neighbors, one read per step
      5'd1:  u.rd_cur = 1'b1;
      5'd2:  begin
        u.rd_cur = 1'b1; u.take_self = 1'b1;
        u.rsel = OFS_MINUS; u.csel = OFS_MINUS;
      end
      5'd3:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_MINUS; u.csel = OFS_CENTER;
      end
      5'd4:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_MINUS; u.csel = OFS_PLUS;
      end
      5'd5:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_CENTER; u.csel = OFS_MINUS;
      end
      5'd6:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_CENTER; u.csel = OFS_PLUS;
      end
      5'd7:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_PLUS; u.csel = OFS_MINUS;
      end
      5'd8:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_PLUS; u.csel = OFS_CENTER;
      end
      5'd9:  begin
        u.rd_cur = 1'b1; u.count_nb = 1'b1;
        u.rsel = OFS_PLUS; u.csel = OFS_PLUS;
      end
      5'd10: u.count_nb = 1'b1;
      5'd11: begin u.wr_next = 1'b1; u.last = 1'b1; end
      // write
      5'd12: begin u.wr_cur = 1'b1; u.last = 1'b1; end
      // read
      5'd13: u.rd_cur = 1'b1;
      5'd14: begin u.take_read = 1'b1; u.last = 1'b1; end
      // swap
      5'd15: begin u.swap = 1'b1; u.last = 1'b1; end
      // bad coordinate: result only
      5'd16: u.last = 1'b1;
      default: u.last = 1'b1;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: design/llca_channels.sv
// Valid/ready channel interfaces of the cell engine: command in, response out.
// Depends on llca_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface llca_cmd_if;
  import llca_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FUNC_BITS-1:0]  func;
  logic [ROW_BITS-1:0]   row;
  logic [COL_BITS-1:0]   column;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, func, row, column, write_value, input ready);
  modport sink   (input valid, func, row, column, write_value, output ready);
endinterface

interface llca_rsp_if;
  import llca_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_out;
  logic [COUNT_BITS-1:0] neighbour_count;
  logic                  bad_coordinate;

  modport source (output valid, cell_out, neighbour_count, bad_coordinate, input ready);
  modport sink   (input valid, cell_out, neighbour_count, bad_coordinate, output ready);
endinterface

`default_nettype wire

// File: design/life_like_automaton_cell_update.sv
// Life-like automaton cell engine: two cell banks, config registers and a
// microcoded sequencer. Depends on llca_pkg and llca_channels.sv.
//
// Usage:
//   cmd channel: one transaction per command (write, evaluate, swap, read).
//   rsp channel: exactly one transaction per command, in command order.
//   cfg port: cfg_we/cfg_index/cfg_data, written while the block is idle.
//   The grid wraps at grid_width/grid_height; row/column outside it set
// bad_coordinate and the command changes nothing; swap never checks them.
// Sequencing (busy from command acceptance to the end of the microcode
// program; each bank is single port, one access a cycle): evaluate makes
// nine reads of the current bank and one write of the next; read, write,
// swap and bad coordinate take fewer steps. cmd.ready returns the cycle
// after the final step, so commands are taken one at a time.
// The response sits in an output register; the next command is accepted
// while it waits. If the receiver stalls, the sequencer holds in its final
// step until the register frees up.
// Reset: sequencer idle, response empty, bank A current, registers at their
// defaults (128, 128, 3, 2, 3, 255, 1). Bank contents are undefined until
// written; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module life_like_automaton_cell_update (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [llca_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [llca_pkg::CFG_DATA_BITS-1:0] cfg_data,
  llca_cmd_if.sink                               cmd,
  llca_rsp_if.source                             rsp
);
  import llca_pkg::*;

  // Configuration registers
  logic [SIZE_BITS-1:0] grid_width, grid_height;
  logic [RULE_BITS-1:0] birth_count, survive_min, survive_max;
  logic [CELL_BITS-1:0] alive_level, decay_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_BITS'(MAX_WIDTH);
      grid_height <= SIZE_BITS'(MAX_HEIGHT);
      birth_count <= RULE_BITS'(3);
      survive_min <= RULE_BITS'(2);
      survive_max <= RULE_BITS'(3);
      alive_level <= CELL_BITS'(255);
      decay_step  <= CELL_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[SIZE_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[SIZE_BITS-1:0];
        REG_BIRTH_COUNT: birth_count <= cfg_data[RULE_BITS-1:0];
        REG_SURVIVE_MIN: survive_min <= cfg_data[RULE_BITS-1:0];
        REG_SURVIVE_MAX: survive_max <= cfg_data[RULE_BITS-1:0];
        REG_ALIVE_LEVEL: alive_level <= cfg_data[CELL_BITS-1:0];
        REG_DECAY_STEP:  decay_step  <= cfg_data[CELL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size: zero counts as one, clamp at the maximum
  logic [SIZE_BITS-1:0] eff_w, eff_h;
  always_comb begin
    if (grid_width == '0)                          eff_w = SIZE_BITS'(1);
    else if (grid_width > SIZE_BITS'(MAX_WIDTH))   eff_w = SIZE_BITS'(MAX_WIDTH);
    else                                           eff_w = grid_width;
    if (grid_height == '0)                         eff_h = SIZE_BITS'(1);
    else if (grid_height > SIZE_BITS'(MAX_HEIGHT)) eff_h = SIZE_BITS'(MAX_HEIGHT);
    else                                           eff_h = grid_height;
  end

  // Sequencer state
  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  uop_t                  u;
  logic                  advance;
  logic                  cmd_fire;

  assign u         = uop_rom(step);
  assign cmd.ready = !busy;
  assign cmd_fire  = cmd.valid && cmd.ready;
  // hold in the final step while the response register is full
  assign advance   = busy && !(u.last && rsp.valid && !rsp.ready);

  // Command registers and wrapped neighbor coordinates
  logic [FUNC_BITS-1:0]  func_r;
  logic                  bad;
  logic [ROW_BITS-1:0]   row_c, row_m, row_p;
  logic [COL_BITS-1:0]   col_c, col_m, col_p;
  logic [VALUE_BITS-1:0] wval;
  logic                  bad_in;

  always_comb begin
    bad_in = (func_t'(cmd.func) != FUNC_SWAP) &&
             ((SIZE_BITS'(cmd.row) >= eff_h) || (SIZE_BITS'(cmd.column) >= eff_w));
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      func_r <= cmd.func;
      bad    <= bad_in;
      wval   <= cmd.write_value;
      row_c  <= cmd.row;
      col_c  <= cmd.column;
      row_m  <= (cmd.row == '0) ? ROW_BITS'(eff_h - SIZE_BITS'(1)) :
                                  cmd.row - ROW_BITS'(1);
      row_p  <= (SIZE_BITS'(cmd.row) + SIZE_BITS'(1) == eff_h) ? '0 :
                                  cmd.row + ROW_BITS'(1);
      col_m  <= (cmd.column == '0) ? COL_BITS'(eff_w - SIZE_BITS'(1)) :
                                     cmd.column - COL_BITS'(1);
      col_p  <= (SIZE_BITS'(cmd.column) + SIZE_BITS'(1) == eff_w) ? '0 :
                                     cmd.column + COL_BITS'(1);
    end
  end

  // Step counter with dispatch jump
  logic [STEP_BITS-1:0] disp_target;
  always_comb begin
    if (bad) begin
      disp_target = STEP_BAD;
    end else begin
      unique case (func_t'(func_r))
        FUNC_WRITE: disp_target = STEP_WRITE;
        FUNC_EVAL:  disp_target = STEP_EVAL;
        FUNC_SWAP:  disp_target = STEP_SWAP;
        FUNC_READ:  disp_target = STEP_READ;
        default:    disp_target = STEP_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DISPATCH;
    end else if (cmd_fire) begin
      busy <= 1'b1;
      step <= STEP_DISPATCH;
    end else if (advance) begin
      if (u.last)      busy <= 1'b0;
      else if (u.disp) step <= disp_target;
      else             step <= step + STEP_BITS'(1);
    end
  end

  // Addresses
  logic [ROW_BITS-1:0]  acc_row;
  logic [COL_BITS-1:0]  acc_col;
  logic [ADDR_BITS-1:0] cur_addr, ctr_addr;

  always_comb begin
    unique case (u.rsel)
      OFS_MINUS: acc_row = row_m;
      OFS_PLUS:  acc_row = row_p;
      default:   acc_row = row_c;
    endcase
    unique case (u.csel)
      OFS_MINUS: acc_col = col_m;
      OFS_PLUS:  acc_col = col_p;
      default:   acc_col = col_c;
    endcase
    cur_addr = ADDR_BITS'(ADDR_BITS'(acc_row) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(acc_col));
    ctr_addr = ADDR_BITS'(ADDR_BITS'(row_c) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col_c));
  end

  // Cell banks, single port each; bank_sel = 0 makes bank A current
  logic                 bank_sel;
  logic [CELL_BITS-1:0] bank_a [DEPTH];
  logic [CELL_BITS-1:0] bank_b [DEPTH];
  logic [CELL_BITS-1:0] rdata_a, rdata_b, rdata;
  logic [CELL_BITS-1:0] nv;
  logic [CELL_BITS-1:0] cur_wdata;
  logic                 we_cur, we_nxt, re_cur;
  logic                 we_a, we_b, re_a, re_b;
  logic [ADDR_BITS-1:0] addr_a, addr_b;
  logic [CELL_BITS-1:0] wd_a, wd_b;

  always_comb begin
    cur_wdata = CELL_BITS'(wval);
    we_cur = advance && u.wr_cur;
    we_nxt = advance && u.wr_next;
    re_cur = advance && u.rd_cur;
    we_a   = bank_sel ? we_nxt : we_cur;
    we_b   = bank_sel ? we_cur : we_nxt;
    re_a   = !bank_sel && re_cur;
    re_b   = bank_sel && re_cur;
    addr_a = bank_sel ? ctr_addr : cur_addr;
    addr_b = bank_sel ? cur_addr : ctr_addr;
    wd_a   = bank_sel ? nv : cur_wdata;
    wd_b   = bank_sel ? cur_wdata : nv;
    rdata  = bank_sel ? rdata_b : rdata_a;
  end

  always_ff @(posedge clk) begin
    if (we_a)      bank_a[addr_a] <= wd_a;
    else if (re_a) rdata_a <= bank_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b)      bank_b[addr_b] <= wd_b;
    else if (re_b) rdata_b <= bank_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst)                      bank_sel <= 1'b0;
    else if (advance && u.swap)   bank_sel <= !bank_sel;
  end

  // Evaluate datapath: self value and neighbor count
  logic [CELL_BITS-1:0]  self_val;
  logic [COUNT_BITS-1:0] cnt;

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cnt <= '0;
    end else if (advance) begin
      if (u.take_self) self_val <= rdata;
      if (u.count_nb && (rdata == alive_level)) cnt <= cnt + COUNT_BITS'(1);
    end
  end

  // Rule: birth, survival, else decay with floor at zero
  logic is_alive, born, survives;
  always_comb begin
    is_alive = (self_val == alive_level);
    born     = !is_alive && (cnt == birth_count);
    survives = is_alive && (cnt >= survive_min) && (cnt <= survive_max);
    if (born || survives)          nv = alive_level;
    else if (self_val >= decay_step) nv = self_val - decay_step;
    else                           nv = '0;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance && u.last) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && u.last) begin
      if (u.wr_next)        rsp.cell_out <= VALUE_BITS'(nv);
      else if (u.take_read) rsp.cell_out <= VALUE_BITS'(rdata);
      else                  rsp.cell_out <= '0;
      rsp.neighbour_count <= u.wr_next ? cnt : '0;
      rsp.bad_coordinate  <= bad;
    end
  end

endmodule

`default_nettype wire
